### rtl/ps2m_pkg.sv
`timescale 1ns / 1ps
package ps2m_pkg;

   localparam int CODE_W = 8;
   localparam int NOTE_W = 7;
   localparam int TBL_DEPTH = 256;
   localparam int ADDR_W = $clog2(TBL_DEPTH);

   localparam logic [1:0] OP_SCAN   = 2'd0;
   localparam logic [1:0] OP_WR_NRM = 2'd1;
   localparam logic [1:0] OP_WR_EXT = 2'd2;

   localparam logic [1:0] EV_ON  = 2'd0;
   localparam logic [1:0] EV_OFF = 2'd1;
   localparam logic [1:0] EV_ALL = 2'd2;

   localparam logic [CODE_W-1:0] SC_BREAK = 8'hf0;
   localparam logic [CODE_W-1:0] SC_EXT   = 8'he0;
   localparam logic [CODE_W-1:0] SC_PAUSE = 8'he1;
   localparam logic [CODE_W-1:0] SC_CTRL  = 8'h14;
   localparam logic [CODE_W-1:0] SC_NUM   = 8'h77;

   localparam logic [2:0] ACT_NONE   = 3'd0;
   localparam logic [2:0] ACT_MAKE   = 3'd1;
   localparam logic [2:0] ACT_BREAK  = 3'd2;
   localparam logic [2:0] ACT_XMAKE  = 3'd3;
   localparam logic [2:0] ACT_XBREAK = 3'd4;
   localparam logic [2:0] ACT_ALL    = 3'd5;

   typedef struct packed {
      logic       valid;
      logic [2:0] act;
   } decode_type;

   // expected byte at each step of the pause sequence after the leading e1
   function automatic logic [CODE_W-1:0] pause_byte(input logic [2:0] step);
      logic [CODE_W-1:0] b;
      case (step)
         3'd0: b = SC_CTRL;
         3'd1: b = SC_NUM;
         3'd2: b = SC_PAUSE;
         3'd3: b = SC_BREAK;
         3'd4: b = SC_CTRL;
         3'd5: b = SC_BREAK;
         3'd6: b = SC_NUM;
         default: b = SC_NUM;
      endcase
      return b;
   endfunction

endpackage

### rtl/ps2m_chan_if.sv
`timescale 1ns / 1ps
interface ps2m_req_if;
   logic                        valid;
   logic                        ready;
   logic [1:0]                  opcode;
   logic [ps2m_pkg::CODE_W-1:0] code;
   logic [ps2m_pkg::NOTE_W-1:0] table_note;

   modport source (output valid, output opcode, output code, output table_note, input ready);
   modport sink (input valid, input opcode, input code, input table_note, output ready);
endinterface

interface ps2m_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [1:0]                  event_kind;
   logic [ps2m_pkg::NOTE_W-1:0] note;

   modport source (output valid, output event_kind, output note, input ready);
   modport sink (input valid, input event_kind, input note, output ready);
endinterface

### rtl/ps2m_note_ram.sv
`timescale 1ns / 1ps
module ps2m_note_ram (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        wr_en,
   input  logic [ps2m_pkg::ADDR_W-1:0] wr_addr,
   input  logic [ps2m_pkg::NOTE_W-1:0] wr_note,
   input  logic                        rd_en,
   input  logic [ps2m_pkg::ADDR_W-1:0] rd_addr,
   output logic [ps2m_pkg::NOTE_W-1:0] rd_note
);

   logic [ps2m_pkg::NOTE_W-1:0]    note_mem_ff [ps2m_pkg::TBL_DEPTH];
   logic [ps2m_pkg::TBL_DEPTH-1:0] valid_ff;
   logic [ps2m_pkg::NOTE_W-1:0]    rd_note_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         note_mem_ff[wr_addr] <= wr_note;
      end
   end

   // entries never written since reset read as unmapped
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_note_ff <= valid_ff[rd_addr] ? note_mem_ff[rd_addr] : '0;
      end
   end

   assign rd_note = rd_note_ff;

endmodule

### rtl/ps2m_prefix.sv
`timescale 1ns / 1ps
module ps2m_prefix (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic [1:0]                  opcode,
   input  logic [ps2m_pkg::CODE_W-1:0] code,
   output ps2m_pkg::decode_type        dec
);

   localparam logic [3:0] PF_IDLE     = 4'd0;
   localparam logic [3:0] PF_BREAK    = 4'd1;
   localparam logic [3:0] PF_EXT      = 4'd2;
   localparam logic [3:0] PF_EXTBREAK = 4'd3;
   localparam logic [3:0] PF_PAUSE1   = 4'd4;
   localparam logic [3:0] PF_PAUSE7   = 4'd10;

   logic [3:0] state_ff;
   logic [3:0] state_in;
   logic [2:0] act;
   logic [3:0] step;
   logic       scan;

   assign scan = accept && (opcode == ps2m_pkg::OP_SCAN);
   assign step = state_ff - PF_PAUSE1;

   always_comb begin
      state_in = state_ff;
      act      = ps2m_pkg::ACT_NONE;
      if (state_ff >= PF_PAUSE1 && state_ff <= PF_PAUSE7) begin
         if (code != ps2m_pkg::pause_byte(step[2:0])) begin
            state_in = PF_IDLE;
         end else if (state_ff == PF_PAUSE7) begin
            state_in = PF_IDLE;
            act      = ps2m_pkg::ACT_ALL;
         end else begin
            state_in = state_ff + 4'd1;
         end
      end else begin
         case (state_ff)
            PF_BREAK: begin
               state_in = PF_IDLE;
               act      = ps2m_pkg::ACT_BREAK;
            end
            PF_EXT: begin
               if (code == ps2m_pkg::SC_BREAK) begin
                  state_in = PF_EXTBREAK;
               end else begin
                  state_in = PF_IDLE;
                  act      = ps2m_pkg::ACT_XMAKE;
               end
            end
            PF_EXTBREAK: begin
               state_in = PF_IDLE;
               act      = ps2m_pkg::ACT_XBREAK;
            end
            default: begin
               if (code == ps2m_pkg::SC_BREAK) begin
                  state_in = PF_BREAK;
               end else if (code == ps2m_pkg::SC_EXT) begin
                  state_in = PF_EXT;
               end else if (code == ps2m_pkg::SC_PAUSE) begin
                  state_in = PF_PAUSE1;
               end else begin
                  state_in = PF_IDLE;
                  act      = ps2m_pkg::ACT_MAKE;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= PF_IDLE;
      end else if (scan) begin
         state_ff <= state_in;
      end
   end

   assign dec.valid = scan && (act != ps2m_pkg::ACT_NONE);
   assign dec.act   = act;

endmodule

### rtl/ps2m_event.sv
`timescale 1ns / 1ps
module ps2m_event (
   input  logic                        clock,
   input  logic                        reset,
   input  ps2m_pkg::decode_type        dec,
   input  logic [ps2m_pkg::NOTE_W-1:0] normal_note,
   input  logic [ps2m_pkg::NOTE_W-1:0] ext_note,
   output logic                        take,
   ps2m_rsp_if.source                  rsp_ch
);

   logic                        s1_valid_ff;
   logic [2:0]                  s1_act_ff;
   logic                        out_valid_ff;
   logic                        out_valid_in;
   logic [1:0]                  out_kind_ff;
   logic [1:0]                  out_kind_in;
   logic [ps2m_pkg::NOTE_W-1:0] out_note_ff;
   logic [ps2m_pkg::NOTE_W-1:0] out_note_in;
   logic [ps2m_pkg::NOTE_W-1:0] last_ff;
   logic [ps2m_pkg::NOTE_W-1:0] last_in;
   logic [ps2m_pkg::NOTE_W-1:0] n;
   logic                        s1_adv;
   logic                        is_ext;

   assign s1_adv = !out_valid_ff || rsp_ch.ready;
   assign take   = !s1_valid_ff || s1_adv;
   assign is_ext = (s1_act_ff == ps2m_pkg::ACT_XMAKE) || (s1_act_ff == ps2m_pkg::ACT_XBREAK);
   assign n      = is_ext ? ext_note : normal_note;

   always_comb begin
      out_valid_in = 1'b0;
      out_kind_in  = ps2m_pkg::EV_ON;
      out_note_in  = n;
      last_in      = last_ff;
      if (s1_valid_ff) begin
         case (s1_act_ff)
            ps2m_pkg::ACT_MAKE, ps2m_pkg::ACT_XMAKE: begin
               if (n != '0 && n != last_ff) begin
                  out_valid_in = 1'b1;
                  last_in      = n;
               end
            end
            ps2m_pkg::ACT_BREAK, ps2m_pkg::ACT_XBREAK: begin
               out_kind_in = ps2m_pkg::EV_OFF;
               if (n != '0) begin
                  out_valid_in = 1'b1;
                  if (n == last_ff) begin
                     last_in = '0;
                  end
               end
            end
            ps2m_pkg::ACT_ALL: begin
               out_valid_in = 1'b1;
               out_kind_in  = ps2m_pkg::EV_ALL;
               out_note_in  = '0;
               last_in      = '0;
            end
            default: begin
               out_valid_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         last_ff      <= '0;
      end else begin
         if (take) begin
            s1_valid_ff <= dec.valid;
         end
         if (s1_adv) begin
            out_valid_ff <= out_valid_in;
            last_ff      <= last_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_act_ff <= dec.act;
      end
      if (s1_adv) begin
         out_kind_ff <= out_kind_in;
         out_note_ff <= out_note_in;
      end
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.event_kind = out_kind_ff;
   assign rsp_ch.note       = out_note_ff;

endmodule

### rtl/ps2_scancode_to_midi_note.sv
`timescale 1ns / 1ps
// path: a taken transaction passes the note table read stage, then the event register,
// before its result is shown
// throughput: one transaction per cycle; the input stalls only while the table read stage
// and the event register both hold and the result is not taken
// reset: synchronous; prefix idle, last note-on cleared, both note tables read as unmapped
module ps2_scancode_to_midi_note (
   input  logic        clock,
   input  logic        reset,
   ps2m_req_if.sink    req_ch,
   ps2m_rsp_if.source  rsp_ch
);

   ps2m_pkg::decode_type        dec;
   logic                        take;
   logic                        accept;
   logic                        rd_nrm;
   logic                        rd_ext;
   logic [ps2m_pkg::NOTE_W-1:0] normal_note;
   logic [ps2m_pkg::NOTE_W-1:0] ext_note;

   assign req_ch.ready = take;
   assign accept       = req_ch.valid && take;

   assign rd_nrm = dec.valid
      && (dec.act == ps2m_pkg::ACT_MAKE || dec.act == ps2m_pkg::ACT_BREAK);
   assign rd_ext = dec.valid
      && (dec.act == ps2m_pkg::ACT_XMAKE || dec.act == ps2m_pkg::ACT_XBREAK);

   ps2m_prefix u_prefix (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .opcode (req_ch.opcode),
      .code   (req_ch.code),
      .dec    (dec)
   );

   ps2m_note_ram u_nrm_ram (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (accept && req_ch.opcode == ps2m_pkg::OP_WR_NRM),
      .wr_addr (req_ch.code),
      .wr_note (req_ch.table_note),
      .rd_en   (rd_nrm),
      .rd_addr (req_ch.code),
      .rd_note (normal_note)
   );

   ps2m_note_ram u_ext_ram (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (accept && req_ch.opcode == ps2m_pkg::OP_WR_EXT),
      .wr_addr (req_ch.code),
      .wr_note (req_ch.table_note),
      .rd_en   (rd_ext),
      .rd_addr (req_ch.code),
      .rd_note (ext_note)
   );

   ps2m_event u_event (
      .clock       (clock),
      .reset       (reset),
      .dec         (dec),
      .normal_note (normal_note),
      .ext_note    (ext_note),
      .take        (take),
      .rsp_ch      (rsp_ch)
   );

`ifndef SYNTHESIS
   a_all_off_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.event_kind == ps2m_pkg::EV_ALL |-> rsp_ch.note == '0)
      else $error("all notes off with nonzero note");

   a_note_on_mapped: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.event_kind == ps2m_pkg::EV_ON |-> rsp_ch.note != '0)
      else $error("note on for unmapped key");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_ch.valid)
      else $error("result valid after reset");

   a_no_dual_read: assert property (@(posedge clock) disable iff (reset)
      !(rd_nrm && rd_ext))
      else $error("both note tables read in one cycle");
`endif

endmodule
